>>> rtl/gsv_pkg.sv
`default_nettype none
package gsv_pkg;

  localparam int EARTH_RADIUS_M = 6371000;
  localparam int STATION_X_RST  = 6371000;
  localparam int MASK_W         = 18;
  localparam int MASK_RST       = 10240;
  localparam int ELEV_LIMIT     = 92160;

  localparam int DIV_STEPS    = 30;
  localparam int MAG_W        = DIV_STEPS + 1;
  localparam int COS_W        = MAG_W + 1;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int CORDIC_STEPS = 23;
  localparam int CORDIC_XW    = 34;
  localparam int CORDIC_ZW    = 26;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117285, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  localparam logic [1:0] CFG_STATION_X = 2'd0;
  localparam logic [1:0] CFG_STATION_Y = 2'd1;
  localparam logic [1:0] CFG_STATION_Z = 2'd2;
  localparam logic [1:0] CFG_ELEV_MASK = 2'd3;

  typedef enum logic [2:0] {
    V_VISIBLE    = 3'd0,
    V_NOT_SAT    = 3'd1,
    V_BEHIND     = 3'd2,
    V_BLOCKED    = 3'd3,
    V_BELOW_MASK = 3'd4
  } verdict_t;

endpackage
`default_nettype wire

>>> rtl/ground_station_visibility.sv
// Channel   Handshake              Payload
// input     start / busy           in_sat_x, in_sat_y, in_sat_z, in_is_satellite
// result    out_valid (strobe)     out_visible, out_verdict, out_elevation
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is taken every cycle; busy stays low and cfg_ready stays high.
// The pipeline runs through the chain of length root, divide, sine root and
// CORDIC cells, one step per cell.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default station.
// The receiver cannot stall; each result is on the ports for one cycle.
`default_nettype none
module ground_station_visibility import gsv_pkg::*; #(
  parameter int COORD_BITS = 27
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_sat_x,
  input  wire logic signed [COORD_BITS-1:0] in_sat_y,
  input  wire logic signed [COORD_BITS-1:0] in_sat_z,
  input  wire logic                         in_is_satellite,
  output logic                              out_valid,
  output logic                              out_visible,
  output logic             [2:0]            out_verdict,
  output logic signed      [MASK_W-1:0]     out_elevation,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic        [1:0]            cfg_index,
  input  wire logic        [COORD_BITS-1:0] cfg_data
);

  localparam int CW     = (COORD_BITS > 28) ? 28 : COORD_BITS;
  localparam int PS     = COORD_BITS - CW;
  localparam int LW     = CW + 1;
  localparam int DW     = 2 * CW + 2;
  localparam int BW     = DW + 6;
  localparam int K1     = CW + 1;
  localparam int K2     = MAG_W;
  localparam int CLW    = LW + 1;
  localparam int EW     = CORDIC_ZW - 6;
  localparam int RADIUS = EARTH_RADIUS_M >>> PS;
  localparam int LAT    = 3 + K1 + 2 + DIV_STEPS + 2 + K2 + 1 + CORDIC_STEPS + 1;

  typedef struct packed {
    logic                 is_sat;
    logic signed [DW-1:0] dot;
    logic signed [DW-1:0] gd;
  } side1_t;

  typedef struct packed {
    logic          is_sat;
    logic          behind;
    logic          ez;
    logic [LW-1:0] slen;
    logic [1:0]    neg;
    logic [1:0]    lim;
  } side2_t;

  typedef struct packed {
    logic                    is_sat;
    logic                    behind;
    logic                    ez;
    logic [LW-1:0]           slen;
    logic signed [COS_W-1:0] cos_e;
  } side3_t;

  typedef struct packed {
    logic           is_sat;
    logic           behind;
    logic           ez;
    logic [CLW-1:0] clear;
  } side4_t;

  // configuration
  logic signed [COORD_BITS-1:0] stn_r [3];
  logic signed [MASK_W-1:0]     mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stn_r[0] <= COORD_BITS'(STATION_X_RST);
      stn_r[1] <= '0;
      stn_r[2] <= '0;
      mask_r   <= MASK_W'(MASK_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STATION_X: stn_r[0] <= cfg_data;
        CFG_STATION_Y: stn_r[1] <= cfg_data;
        CFG_STATION_Z: stn_r[2] <= cfg_data;
        CFG_ELEV_MASK: mask_r   <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // valid line
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // stage 1: coordinates and differences
  logic signed [CW-1:0] g_w [3];
  logic signed [CW-1:0] s_w [3];
  logic signed [CW-1:0] s1_s_r [3];
  logic signed [CW:0]   s1_d_r [3];
  logic                 s1_sat_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      g_w[a] = $signed(stn_r[a][COORD_BITS-1:PS]);
    end
    s_w[0] = $signed(in_sat_x[COORD_BITS-1:PS]);
    s_w[1] = $signed(in_sat_y[COORD_BITS-1:PS]);
    s_w[2] = $signed(in_sat_z[COORD_BITS-1:PS]);
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s1_s_r[a] <= s_w[a];
      s1_d_r[a] <= (CW+1)'(s_w[a]) - (CW+1)'(g_w[a]);
    end
    s1_sat_r <= in_is_satellite;
  end

  // stage 2: products
  logic signed [2*CW-1:0] s2_gg_r [3];
  logic signed [2*CW-1:0] s2_ss_r [3];
  logic signed [DW-1:0]   s2_dd_r [3];
  logic signed [2*CW-1:0] s2_gs_r [3];
  logic signed [2*CW:0]   s2_gd_r [3];
  logic                   s2_sat_r;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s2_gg_r[a] <= (2*CW)'(g_w[a]) * (2*CW)'(g_w[a]);
      s2_ss_r[a] <= (2*CW)'(s1_s_r[a]) * (2*CW)'(s1_s_r[a]);
      s2_dd_r[a] <= DW'(s1_d_r[a]) * DW'(s1_d_r[a]);
      s2_gs_r[a] <= (2*CW)'(g_w[a]) * (2*CW)'(s1_s_r[a]);
      s2_gd_r[a] <= (2*CW+1)'(g_w[a]) * (2*CW+1)'(s1_d_r[a]);
    end
    s2_sat_r <= s1_sat_r;
  end

  // stage 3: sums
  logic [DW-1:0] s3_rad_r [3];
  side1_t        s3_side_r;

  always_ff @(posedge clk) begin
    s3_rad_r[0] <= DW'(s2_gg_r[0]) + DW'(s2_gg_r[1]) + DW'(s2_gg_r[2]);
    s3_rad_r[1] <= DW'(s2_ss_r[0]) + DW'(s2_ss_r[1]) + DW'(s2_ss_r[2]);
    s3_rad_r[2] <= s2_dd_r[0] + s2_dd_r[1] + s2_dd_r[2];
    s3_side_r.is_sat <= s2_sat_r;
    s3_side_r.dot    <= DW'(s2_gs_r[0]) + DW'(s2_gs_r[1]) + DW'(s2_gs_r[2]);
    s3_side_r.gd     <= DW'(s2_gd_r[0]) + DW'(s2_gd_r[1]) + DW'(s2_gd_r[2]);
  end

  // length roots: station, satellite, station-to-satellite
  logic [DW-1:0]             q1_rem  [K1+1][3];
  logic [DW-1:0]             q1_root [K1+1][3];
  logic [$bits(side1_t)-1:0] q1_side [K1+1];

  assign q1_rem[0]  = s3_rad_r;
  assign q1_root[0] = '{default: '0};
  assign q1_side[0] = s3_side_r;

  for (genvar j = 0; j < K1; j++) begin : g_sq1
    gsv_sqrt_cell #(
      .RW(DW), .STEP(K1 - 1 - j), .LANES(3), .SW($bits(side1_t))
    ) u_cell (
      .clk,
      .rem_i(q1_rem[j]), .root_i(q1_root[j]), .side_i(q1_side[j]),
      .rem_o(q1_rem[j+1]), .root_o(q1_root[j+1]), .side_o(q1_side[j+1])
    );
  end

  side1_t        p_in;
  logic [LW-1:0] glen, slen, dlen;

  assign p_in = q1_side[K1];
  assign glen = q1_root[K1][0][LW-1:0];
  assign slen = q1_root[K1][1][LW-1:0];
  assign dlen = q1_root[K1][2][LW-1:0];

  // stage P: denominators
  logic [DW-1:0]        p_den_r [2];
  logic signed [DW-1:0] p_num_r [2];
  logic [LW-1:0]        p_slen_r;
  logic                 p_ez_r, p_sat_r;

  always_ff @(posedge clk) begin
    p_den_r[0] <= DW'(glen) * DW'(dlen);
    p_den_r[1] <= DW'(glen) * DW'(slen);
    p_num_r[0] <= p_in.gd;
    p_num_r[1] <= p_in.dot;
    p_slen_r   <= slen;
    p_ez_r     <= (glen == '0) || (dlen == '0);
    p_sat_r    <= p_in.is_sat;
  end

  // stage Q: behind test, divider set-up
  logic [DW-1:0]        q_mag [2];
  logic [1:0]           q_lim, q_neg;
  logic signed [BW-1:0] q_dot20, q_negden;
  logic [DW:0]          qd_rem_r [2];
  logic [DW-1:0]        qd_den_r [2];
  side2_t               qd_side_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_neg[l] = p_num_r[l] < 0;
      q_mag[l] = q_neg[l] ? DW'(-p_num_r[l]) : DW'(p_num_r[l]);
      q_lim[l] = q_mag[l] >= p_den_r[l];
    end
    q_dot20  = BW'(p_num_r[1]) * BW'(20);
    q_negden = -$signed(BW'(p_den_r[1]));
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      qd_rem_r[l] <= {1'b0, q_mag[l]};
      qd_den_r[l] <= p_den_r[l];
    end
    qd_side_r.is_sat <= p_sat_r;
    qd_side_r.behind <= q_dot20 < q_negden;
    qd_side_r.ez     <= p_ez_r;
    qd_side_r.slen   <= p_slen_r;
    qd_side_r.neg    <= q_neg;
    qd_side_r.lim    <= q_lim;
  end

  // cosine dividers: elevation lane 0, center angle lane 1
  logic [DW:0]               dv_rem  [DIV_STEPS+1][2];
  logic [DIV_STEPS-1:0]      dv_quo  [DIV_STEPS+1][2];
  logic [DW-1:0]             dv_den  [DIV_STEPS+1][2];
  logic [$bits(side2_t)-1:0] dv_side [DIV_STEPS+1];

  assign dv_rem[0]  = qd_rem_r;
  assign dv_quo[0]  = '{default: '0};
  assign dv_den[0]  = qd_den_r;
  assign dv_side[0] = qd_side_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    gsv_div_cell #(
      .DW(DW), .LANES(2), .SW($bits(side2_t))
    ) u_cell (
      .clk,
      .rem_i(dv_rem[j]), .quo_i(dv_quo[j]), .den_i(dv_den[j]), .side_i(dv_side[j]),
      .rem_o(dv_rem[j+1]), .quo_o(dv_quo[j+1]), .den_o(dv_den[j+1]),
      .side_o(dv_side[j+1])
    );
  end

  // stage SS: signed cosine, square
  side2_t                  ss_in;
  logic [MAG_W-1:0]        ss_mag [2];
  logic signed [COS_W-1:0] ss_cos_r [2];
  logic [SQ_W-1:0]         ss_sq_r  [2];
  side2_t                  ss_side_r;

  assign ss_in = dv_side[DIV_STEPS];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ss_mag[l] = ss_in.lim[l] ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, dv_quo[DIV_STEPS][l]};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      ss_cos_r[l] <= ss_in.neg[l] ? -$signed(COS_W'(ss_mag[l])) : $signed(COS_W'(ss_mag[l]));
      ss_sq_r[l]  <= SQ_W'(ss_mag[l]) * SQ_W'(ss_mag[l]);
    end
    ss_side_r <= ss_in;
  end

  // stage ST: sine radicand
  logic [SQ_W-1:0] st_rad_r [2];
  side3_t          st_side_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      st_rad_r[l] <= (SQ_W'(1) << (2 * DIV_STEPS)) - ss_sq_r[l];
    end
    st_side_r.is_sat <= ss_side_r.is_sat;
    st_side_r.behind <= ss_side_r.behind;
    st_side_r.ez     <= ss_side_r.ez;
    st_side_r.slen   <= ss_side_r.slen;
    st_side_r.cos_e  <= ss_cos_r[0];
  end

  // sine roots
  logic [SQ_W-1:0]           q2_rem  [K2+1][2];
  logic [SQ_W-1:0]           q2_root [K2+1][2];
  logic [$bits(side3_t)-1:0] q2_side [K2+1];

  assign q2_rem[0]  = st_rad_r;
  assign q2_root[0] = '{default: '0};
  assign q2_side[0] = st_side_r;

  for (genvar j = 0; j < K2; j++) begin : g_sq2
    gsv_sqrt_cell #(
      .RW(SQ_W), .STEP(K2 - 1 - j), .LANES(2), .SW($bits(side3_t))
    ) u_cell (
      .clk,
      .rem_i(q2_rem[j]), .root_i(q2_root[j]), .side_i(q2_side[j]),
      .rem_o(q2_rem[j+1]), .root_o(q2_root[j+1]), .side_o(q2_side[j+1])
    );
  end

  // stage SU: clearance, CORDIC set-up
  side3_t                      su_in;
  logic [MAG_W-1:0]            sin_e, sin_c;
  logic [LW+MAG_W-1:0]         su_prod;
  logic signed [CORDIC_XW-1:0] su_x_r, su_y_r;
  side4_t                      su_side_r;

  assign su_in   = q2_side[K2];
  assign sin_e   = q2_root[K2][0][MAG_W-1:0];
  assign sin_c   = q2_root[K2][1][MAG_W-1:0];
  assign su_prod = (LW+MAG_W)'(su_in.slen) * (LW+MAG_W)'(sin_c);

  always_ff @(posedge clk) begin
    su_x_r           <= $signed(CORDIC_XW'(sin_e));
    su_y_r           <= CORDIC_XW'(su_in.cos_e);
    su_side_r.is_sat <= su_in.is_sat;
    su_side_r.behind <= su_in.behind;
    su_side_r.ez     <= su_in.ez;
    su_side_r.clear  <= su_prod[LW+MAG_W-1:DIV_STEPS];
  end

  // CORDIC angle
  logic signed [CORDIC_XW-1:0] cd_x [CORDIC_STEPS+1];
  logic signed [CORDIC_XW-1:0] cd_y [CORDIC_STEPS+1];
  logic signed [CORDIC_ZW-1:0] cd_z [CORDIC_STEPS+1];
  logic [$bits(side4_t)-1:0]   cd_side [CORDIC_STEPS+1];

  assign cd_x[0]    = su_x_r;
  assign cd_y[0]    = su_y_r;
  assign cd_z[0]    = '0;
  assign cd_side[0] = su_side_r;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    gsv_cordic_cell #(
      .STEP(j), .SW($bits(side4_t))
    ) u_cell (
      .clk,
      .x_i(cd_x[j]), .y_i(cd_y[j]), .z_i(cd_z[j]), .side_i(cd_side[j]),
      .x_o(cd_x[j+1]), .y_o(cd_y[j+1]), .z_o(cd_z[j+1]), .side_o(cd_side[j+1])
    );
  end

  // output stage
  side4_t                      fo_in;
  logic signed [CORDIC_ZW-1:0] fo_round;
  logic signed [EW-1:0]        fo_elev;
  logic signed [MASK_W-1:0]    elev_nxt;
  verdict_t                    verdict_nxt;
  logic                        out_visible_r;
  verdict_t                    out_verdict_r;
  logic signed [MASK_W-1:0]    out_elevation_r;

  assign fo_in = cd_side[CORDIC_STEPS];

  always_comb begin
    fo_round = cd_z[CORDIC_STEPS] + CORDIC_ZW'(32);
    fo_elev  = $signed(fo_round[CORDIC_ZW-1:6]);
    if (fo_in.ez || fo_elev > EW'(ELEV_LIMIT)) begin
      elev_nxt = MASK_W'(ELEV_LIMIT);
    end else if (fo_elev < -EW'(ELEV_LIMIT)) begin
      elev_nxt = -MASK_W'(ELEV_LIMIT);
    end else begin
      elev_nxt = fo_elev[MASK_W-1:0];
    end
    if (!fo_in.is_sat) begin
      verdict_nxt = V_NOT_SAT;
    end else if (fo_in.behind) begin
      verdict_nxt = V_BEHIND;
    end else if (32'(fo_in.clear) <= 32'(RADIUS)) begin
      verdict_nxt = V_BLOCKED;
    end else if (elev_nxt < mask_r) begin
      verdict_nxt = V_BELOW_MASK;
    end else begin
      verdict_nxt = V_VISIBLE;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r   <= verdict_nxt == V_VISIBLE;
    out_verdict_r   <= verdict_nxt;
    out_elevation_r <= elev_nxt;
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_visible   = out_visible_r;
  assign out_verdict   = out_verdict_r;
  assign out_elevation = out_elevation_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("result strobe missing after pipeline latency");

  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_visible == (out_verdict == V_VISIBLE))
    else $error("visible flag disagrees with verdict");

  a_mask_met: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == V_VISIBLE |-> out_elevation >= mask_r)
    else $error("visible beat below elevation mask");

  a_mask_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == V_BELOW_MASK |-> out_elevation < mask_r)
    else $error("below-mask verdict with elevation at or above mask");

endmodule
`default_nettype wire

>>> rtl/gsv_sqrt_cell.sv
`default_nettype none
module gsv_sqrt_cell #(
  parameter int RW    = 58,
  parameter int STEP  = 0,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  wire logic          clk,
  input  wire logic [RW-1:0] rem_i  [LANES],
  input  wire logic [RW-1:0] root_i [LANES],
  input  wire logic [SW-1:0] side_i,
  output logic      [RW-1:0] rem_o  [LANES],
  output logic      [RW-1:0] root_o [LANES],
  output logic      [SW-1:0] side_o
);

  localparam logic [RW:0] BIT = (RW+1)'(1) << (2 * STEP);

  logic [RW:0]   trial    [LANES];
  logic [RW-1:0] rem_nxt  [LANES];
  logic [RW-1:0] root_nxt [LANES];
  logic [RW-1:0] rem_r    [LANES];
  logic [RW-1:0] root_r   [LANES];
  logic [SW-1:0] side_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = {1'b0, root_i[l]} + BIT;
      if ({1'b0, rem_i[l]} >= trial[l]) begin
        rem_nxt[l]  = rem_i[l] - trial[l][RW-1:0];
        root_nxt[l] = (root_i[l] >> 1) + BIT[RW-1:0];
      end else begin
        rem_nxt[l]  = rem_i[l];
        root_nxt[l] = root_i[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= side_i;
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

>>> rtl/gsv_div_cell.sv
`default_nettype none
module gsv_div_cell import gsv_pkg::*; #(
  parameter int DW    = 56,
  parameter int LANES = 2,
  parameter int SW    = 1
) (
  input  wire logic                 clk,
  input  wire logic [DW:0]          rem_i [LANES],
  input  wire logic [DIV_STEPS-1:0] quo_i [LANES],
  input  wire logic [DW-1:0]        den_i [LANES],
  input  wire logic [SW-1:0]        side_i,
  output logic      [DW:0]          rem_o [LANES],
  output logic      [DIV_STEPS-1:0] quo_o [LANES],
  output logic      [DW-1:0]        den_o [LANES],
  output logic      [SW-1:0]        side_o
);

  logic [DW:0]          twice   [LANES];
  logic [DW:0]          rem_nxt [LANES];
  logic [DIV_STEPS-1:0] quo_nxt [LANES];
  logic [DW:0]          rem_r   [LANES];
  logic [DIV_STEPS-1:0] quo_r   [LANES];
  logic [DW-1:0]        den_r   [LANES];
  logic [SW-1:0]        side_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      twice[l] = {rem_i[l][DW-1:0], 1'b0};
      if (twice[l] >= {1'b0, den_i[l]}) begin
        rem_nxt[l] = twice[l] - {1'b0, den_i[l]};
        quo_nxt[l] = {quo_i[l][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[l] = twice[l];
        quo_nxt[l] = {quo_i[l][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_i;
    side_r <= side_i;
  end

  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

>>> rtl/gsv_cordic_cell.sv
`default_nettype none
module gsv_cordic_cell import gsv_pkg::*; #(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  wire logic                        clk,
  input  wire logic signed [CORDIC_XW-1:0] x_i,
  input  wire logic signed [CORDIC_XW-1:0] y_i,
  input  wire logic signed [CORDIC_ZW-1:0] z_i,
  input  wire logic        [SW-1:0]        side_i,
  output logic signed      [CORDIC_XW-1:0] x_o,
  output logic signed      [CORDIC_XW-1:0] y_o,
  output logic signed      [CORDIC_ZW-1:0] z_o,
  output logic             [SW-1:0]        side_o
);

  localparam logic signed [CORDIC_ZW-1:0] ANG = CORDIC_ZW'(ATAN_TAB[STEP]);

  logic signed [CORDIC_XW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [CORDIC_ZW-1:0] z_nxt;
  logic signed [CORDIC_XW-1:0] x_r, y_r;
  logic signed [CORDIC_ZW-1:0] z_r;
  logic        [SW-1:0]        side_r;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (y_i > 0) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= side_i;
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

>>> bench/tb_ground_station_visibility.sv
`timescale 1ns / 1ps
module tb_ground_station_visibility;
  import gsv_pkg::*;

  localparam int CB = 27;
  localparam int LATENCY = 121;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 is_sat;
  } sat_pos_t;

  typedef struct {
    logic                     visible;
    verdict_t                 verdict;
    logic signed [MASK_W-1:0] elevation;
  } link_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] in_sat_x = '0, in_sat_y = '0, in_sat_z = '0;
  logic in_is_satellite = 1'b0;
  logic out_valid, out_visible;
  logic [2:0] out_verdict;
  logic signed [MASK_W-1:0] out_elevation;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_STATION_X;
  logic [CB-1:0] cfg_data = '0;

  // predictor copy of the configuration
  logic signed [CB-1:0] stn_x = STATION_X_RST, stn_y = '0, stn_z = '0;
  logic signed [MASK_W-1:0] mask_q = MASK_RST;

  sat_pos_t pending_pos[$];
  link_t    expected_links[$];
  int       mismatches = 0;
  int       gap = 0;
  bit       idling = 1'b1;

  always #6 clk = ~clk;

  ground_station_visibility #(.COORD_BITS(CB)) i_dut (
    .clk, .rst_n, .start, .busy,
    .in_sat_x, .in_sat_y, .in_sat_z, .in_is_satellite,
    .out_valid, .out_visible, .out_verdict, .out_elevation,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cos_q30(longint num, longint unsigned den);
    longint unsigned mag, q, r;
    mag = num < 0 ? longint'(-num) : longint'(num);
    q = 0;
    if (mag >= den) begin
      q = 64'd1 << 30;
    end else begin
      r = mag;
      for (int i = 0; i < 30; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
    end
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sin_q30(longint c);
    longint unsigned m;
    m = c < 0 ? longint'(-c) : longint'(c);
    return longint'(isqrt64((64'd1 << 60) - m * m));
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, ddx, ddy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (y > 0) begin
        x += ddx;
        y -= ddy;
        z += ATAN_TAB[i];
      end else begin
        x -= ddx;
        y += ddy;
        z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic link_t predict_link(sat_pos_t p);
    longint gx, gy, gz, sx, sy, sz, dx, dy, dz, dot, gd, cosc, clr, elev, c, mk;
    longint unsigned glen, slen, dlen;
    link_t r;
    gx = stn_x; gy = stn_y; gz = stn_z;
    sx = p.x; sy = p.y; sz = p.z;
    mk = mask_q;
    dx = sx - gx; dy = sy - gy; dz = sz - gz;
    glen = isqrt64(gx * gx + gy * gy + gz * gz);
    slen = isqrt64(sx * sx + sy * sy + sz * sz);
    dlen = isqrt64(dx * dx + dy * dy + dz * dz);
    dot = gx * sx + gy * sy + gz * sz;
    gd = gx * dx + gy * dy + gz * dz;
    if (glen == 0 || dlen == 0) begin
      elev = ELEV_LIMIT;
    end else begin
      c = cos_q30(gd, glen * dlen);
      elev = (vector_angle(sin_q30(c), c) + 32) >>> 6;
      if (elev > ELEV_LIMIT) elev = ELEV_LIMIT;
      if (elev < -ELEV_LIMIT) elev = -ELEV_LIMIT;
    end
    if (glen == 0 || slen == 0) cosc = longint'(1) << 30;
    else cosc = cos_q30(dot, glen * slen);
    clr = longint'((slen * longint'(sin_q30(cosc))) >> 30);
    if (!p.is_sat) r.verdict = V_NOT_SAT;
    else if (20 * dot < -longint'(glen * slen)) r.verdict = V_BEHIND;
    else if (clr <= EARTH_RADIUS_M) r.verdict = V_BLOCKED;
    else if (elev < mk) r.verdict = V_BELOW_MASK;
    else r.verdict = V_VISIBLE;
    r.visible = r.verdict == V_VISIBLE;
    r.elevation = elev[MASK_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    sat_pos_t p;
    if (rst_n) begin
      if (start && !busy) expected_links.push_back(predict_link(
          '{x: in_sat_x, y: in_sat_y, z: in_sat_z, is_sat: in_is_satellite}));
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (idling && $urandom_range(5) == 0) begin
        gap <= $urandom_range(8);
        start <= 1'b0;
      end else if (pending_pos.size() > 0) begin
        p = pending_pos.pop_front();
        in_sat_x <= p.x;
        in_sat_y <= p.y;
        in_sat_z <= p.z;
        in_is_satellite <= p.is_sat;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and config tracking
  always @(posedge clk) begin
    link_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STATION_X: stn_x <= cfg_data;
          CFG_STATION_Y: stn_y <= cfg_data;
          CFG_STATION_Z: stn_z <= cfg_data;
          CFG_ELEV_MASK: mask_q <= cfg_data[MASK_W-1:0];
        endcase
      end
      if (out_valid) begin
        if (expected_links.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: vis %0b verdict %0d elev %0d",
              out_visible, out_verdict, out_elevation);
        end else begin
          e = expected_links.pop_front();
          if (out_visible !== e.visible || out_verdict !== e.verdict ||
              out_elevation !== e.elevation) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp vis %0b verdict %0d elev %0d, got %0b %0d %0d",
                  e.visible, e.verdict, e.elevation, out_visible, out_verdict, out_elevation);
          end
        end
      end
    end
  end

  task automatic add_pos(int x, int y, int z, bit s);
    pending_pos.push_back('{x: x[CB-1:0], y: y[CB-1:0], z: z[CB-1:0], is_sat: s});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_pos.size() != 0 || start || expected_links.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CB-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_station(int x, int y, int z, int m);
    write_reg(CFG_STATION_X, x);
    write_reg(CFG_STATION_Y, y);
    write_reg(CFG_STATION_Z, z);
    write_reg(CFG_ELEV_MASK, m);
  endtask

  task automatic add_random(int n);
    int k, sx, sy, sz;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 6) begin
        sx = int'($urandom_range(16000000)) - 8000000;
        sy = int'($urandom_range(16000000)) - 8000000;
        sz = int'($urandom_range(16000000)) - 8000000;
      end else if (k < 8) begin
        sx = $urandom(); sy = $urandom(); sz = $urandom();
      end else begin
        sx = stn_x + int'($urandom_range(4000000)) - 2000000;
        sy = stn_y + int'($urandom_range(4000000)) - 2000000;
        sz = stn_z + int'($urandom_range(2000)) - 1000;
      end
      add_pos(sx, sy, sz, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed, reset configuration
    add_pos(6371000, 0, 0, 1'b1);
    add_pos(0, 0, 0, 1'b1);
    add_pos(7000000, 0, 0, 1'b0);
    add_pos(7000000, 0, 0, 1'b1);
    add_pos(-7000000, 0, 0, 1'b1);
    add_pos(0, 6000000, 0, 1'b1);
    add_pos(6500000, 2500000, 0, 1'b1);
    add_pos(6800000, 1000000, 300000, 1'b1);
    add_pos(-67108864, -67108864, -67108864, 1'b1);
    add_pos(67108863, 67108863, 67108863, 1'b1);
    add_pos(67108863, -67108864, 0, 1'b1);
    add_pos(6371001, 0, 0, 1'b1);
    drain();
    // station at earth center, extreme masks
    set_station(0, 0, 0, -ELEV_LIMIT);
    add_pos(7000000, 0, 0, 1'b1);
    add_pos(0, 0, 0, 1'b1);
    add_pos(-67108864, 5, 67108863, 1'b1);
    drain();
    set_station(-67108864, 67108863, -67108864, ELEV_LIMIT);
    add_pos(-67108864, 67108863, -67108864, 1'b1);
    add_pos(67108863, -67108864, 67108863, 1'b1);
    add_pos(-67108000, 67108000, -67108000, 1'b1);
    add_random(60);
    drain();
    set_station(0, 6371000, 0, 131071);
    add_pos(0, 7000000, 0, 1'b1);
    add_random(60);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      set_station(int'($urandom_range(10000000)) - 5000000,
                  int'($urandom_range(10000000)) - 5000000,
                  int'($urandom_range(10000000)) - 5000000,
                  int'($urandom_range(2 * ELEV_LIMIT)) - ELEV_LIMIT);
      add_random(90);
      drain();
    end
    set_station(STATION_X_RST, 0, 0, MASK_RST);
    idling = 1'b0;
    add_random(130);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (expected_links.size() != 0) mismatches++;
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("end of test: mismatches");
    $finish;
  end
endmodule
